// ===== hw/rtl/vcs_pkg.sv =====
// ----------------------------------------------------------------------------
// vcs_pkg
// shared constants and codes for the volume component size sum block
// ----------------------------------------------------------------------------
package vcs_pkg;

	localparam int MAX_ROWS_DEF   = 64;
	localparam int MAX_COLS_DEF   = 64;
	localparam int MAX_SLICES_DEF = 16;

	localparam int ROWS_W  = 7;
	localparam int COLS_W  = 7;
	localparam int SLICE_W = 5;
	localparam int TOTAL_W = 17;

	localparam logic [ROWS_W-1:0]  ROWS_RST   = 7'd64;
	localparam logic [COLS_W-1:0]  COLS_RST   = 7'd64;
	localparam logic [SLICE_W-1:0] SLICES_RST = 5'd16;
	localparam logic [TOTAL_W-1:0] MIN_RST    = 17'd1;
	localparam logic [TOTAL_W-1:0] TOTAL_SAT  = 17'h1FFFF;

	localparam int IDX_W = 2;
	typedef enum logic [IDX_W-1:0] {
		REG_ROWS   = 2'd0,
		REG_COLS   = 2'd1,
		REG_SLICES = 2'd2,
		REG_MIN    = 2'd3
	} reg_idx_t;

	// neighbor order within one dequeued item
	localparam logic [2:0] NB_XM   = 3'd0;
	localparam logic [2:0] NB_XP   = 3'd1;
	localparam logic [2:0] NB_YM   = 3'd2;
	localparam logic [2:0] NB_YP   = 3'd3;
	localparam logic [2:0] NB_ZM   = 3'd4;
	localparam logic [2:0] NB_ZP   = 3'd5;
	localparam logic [2:0] NB_LAST = 3'd6;

endpackage

// ===== hw/rtl/vcs_ram.sv =====
// ----------------------------------------------------------------------------
// vcs_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module vcs_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/vcs_engine.sv =====
// ----------------------------------------------------------------------------
// vcs_engine
// load, clear, scan and breadth-first fill sequencer around the three rams
// ----------------------------------------------------------------------------
module vcs_engine #(
	parameter int MAX_ROWS   = vcs_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS   = vcs_pkg::MAX_COLS_DEF,
	parameter int MAX_SLICES = vcs_pkg::MAX_SLICES_DEF,
	localparam int DEPTH = MAX_ROWS * MAX_COLS * MAX_SLICES,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int PW = AW + 1,
	localparam int RW = $clog2(MAX_ROWS + 1),
	localparam int CW = $clog2(MAX_COLS + 1),
	localparam int SW = $clog2(MAX_SLICES + 1),
	localparam int XW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
	localparam int YW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
	localparam int ZW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1,
	localparam int QW = ZW + XW + YW + AW
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         in_voxel,
	input  logic                         in_last,
	input  logic [vcs_pkg::ROWS_W-1:0]   rows,
	input  logic [vcs_pkg::COLS_W-1:0]   cols,
	input  logic [vcs_pkg::SLICE_W-1:0]  slices,
	input  logic [vcs_pkg::TOTAL_W-1:0]  min_size,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [vcs_pkg::TOTAL_W-1:0]  total,
	output logic                         vox_we,
	output logic [AW-1:0]                vox_waddr,
	output logic                         vox_wdata,
	output logic [AW-1:0]                vox_raddr,
	input  logic                         vox_rdata,
	output logic                         vis_we,
	output logic [AW-1:0]                vis_waddr,
	output logic                         vis_wdata,
	output logic [AW-1:0]                vis_raddr,
	input  logic                         vis_rdata,
	output logic                         q_we,
	output logic [AW-1:0]                q_waddr,
	output logic [QW-1:0]                q_wdata,
	output logic [AW-1:0]                q_raddr,
	input  logic [QW-1:0]                q_rdata
);

	typedef enum logic [9:0] {
		ST_LOAD  = 10'b0000000001,
		ST_PLANE = 10'b0000000010,
		ST_VOL   = 10'b0000000100,
		ST_CLEAR = 10'b0000001000,
		ST_SCAN  = 10'b0000010000,
		ST_SCHK  = 10'b0000100000,
		ST_DEQ   = 10'b0001000000,
		ST_DWAIT = 10'b0010000000,
		ST_NBR   = 10'b0100000000,
		ST_DONE  = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [PW-1:0] load_pos_q;
	logic [RW-1:0] r_q;
	logic [CW-1:0] c_q;
	logic [SW-1:0] s_q;
	logic [PW-1:0] plane_q;
	logic [PW-1:0] vol_q;

	logic [PW-1:0] sp_q;
	logic [XW-1:0] sx_q;
	logic [YW-1:0] sy_q;
	logic [ZW-1:0] sz_q;

	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [vcs_pkg::TOTAL_W-1:0] total_q;

	logic [PW-1:0] cp_q;
	logic [XW-1:0] cx_q;
	logic [YW-1:0] cy_q;
	logic [ZW-1:0] cz_q;
	logic [2:0]    k_q;

	logic          pend_s1;
	logic [PW-1:0] np_s1;
	logic [XW-1:0] nx_s1;
	logic [YW-1:0] ny_s1;
	logic [ZW-1:0] nz_s1;

	logic [RW-1:0] r_cl;
	logic [CW-1:0] c_cl;
	logic [SW-1:0] s_cl;

	logic          nb_ok;
	logic [PW-1:0] nb_p;
	logic [XW-1:0] nb_x;
	logic [YW-1:0] nb_y;
	logic [ZW-1:0] nb_z;

	logic                        scan_end;
	logic                        scan_hit;
	logic                        nb_hit;
	logic [vcs_pkg::TOTAL_W:0]   sum;
	logic                        big;

	// dimensions clamped into 1..max
	always_comb begin
		if (rows == '0) r_cl = RW'(1);
		else if (int'(rows) > MAX_ROWS) r_cl = RW'(MAX_ROWS);
		else r_cl = RW'(rows);
		if (cols == '0) c_cl = CW'(1);
		else if (int'(cols) > MAX_COLS) c_cl = CW'(MAX_COLS);
		else c_cl = CW'(cols);
		if (slices == '0) s_cl = SW'(1);
		else if (int'(slices) > MAX_SLICES) s_cl = SW'(MAX_SLICES);
		else s_cl = SW'(slices);
	end

	// neighbor k of the current item
	always_comb begin
		nb_ok = 1'b0;
		nb_p  = cp_q;
		nb_x  = cx_q;
		nb_y  = cy_q;
		nb_z  = cz_q;
		unique case (k_q)
			vcs_pkg::NB_XM: begin
				nb_ok = (cx_q != '0);
				nb_p  = cp_q - PW'(c_q);
				nb_x  = cx_q - XW'(1);
			end
			vcs_pkg::NB_XP: begin
				nb_ok = (RW'(cx_q) + RW'(1)) < r_q;
				nb_p  = cp_q + PW'(c_q);
				nb_x  = cx_q + XW'(1);
			end
			vcs_pkg::NB_YM: begin
				nb_ok = (cy_q != '0);
				nb_p  = cp_q - PW'(1);
				nb_y  = cy_q - YW'(1);
			end
			vcs_pkg::NB_YP: begin
				nb_ok = (CW'(cy_q) + CW'(1)) < c_q;
				nb_p  = cp_q + PW'(1);
				nb_y  = cy_q + YW'(1);
			end
			vcs_pkg::NB_ZM: begin
				nb_ok = (cz_q != '0);
				nb_p  = cp_q - plane_q;
				nb_z  = cz_q - ZW'(1);
			end
			vcs_pkg::NB_ZP: begin
				nb_ok = (SW'(cz_q) + SW'(1)) < s_q;
				nb_p  = cp_q + plane_q;
				nb_z  = cz_q + ZW'(1);
			end
			default: begin
				nb_ok = 1'b0;
			end
		endcase
	end

	assign scan_end = (sp_q + PW'(1)) == vol_q;
	assign scan_hit = (state_q == ST_SCHK) && vox_rdata && !vis_rdata;
	assign nb_hit   = (state_q == ST_NBR) && pend_s1 && vox_rdata && !vis_rdata;
	assign sum      = {1'b0, total_q} + (vcs_pkg::TOTAL_W+1)'(tail_q);
	assign big      = (vcs_pkg::TOTAL_W+1)'(tail_q) >= {1'b0, min_size};

	assign in_ready  = (state_q == ST_LOAD);
	assign res_valid = (state_q == ST_DONE) && res_ready;
	assign total     = total_q;

	assign vox_we    = in_valid && in_ready && (load_pos_q < PW'(DEPTH));
	assign vox_waddr = load_pos_q[AW-1:0];
	assign vox_wdata = in_voxel;
	assign vox_raddr = (state_q == ST_NBR) ? nb_p[AW-1:0] : sp_q[AW-1:0];
	assign vis_raddr = vox_raddr;

	assign vis_we    = (state_q == ST_CLEAR) || scan_hit || nb_hit;
	assign vis_waddr = nb_hit ? np_s1[AW-1:0] : sp_q[AW-1:0];
	assign vis_wdata = (state_q != ST_CLEAR);

	assign q_we    = scan_hit || nb_hit;
	assign q_waddr = nb_hit ? tail_q[AW-1:0] : '0;
	assign q_wdata = nb_hit ? {nz_s1, nx_s1, ny_s1, np_s1[AW-1:0]}
	                        : {sz_q, sx_q, sy_q, sp_q[AW-1:0]};
	assign q_raddr = head_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			load_pos_q <= '0;
			sp_q       <= '0;
			sx_q       <= '0;
			sy_q       <= '0;
			sz_q       <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			total_q    <= '0;
			k_q        <= '0;
			pend_s1    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_valid) begin
						if (load_pos_q < PW'(DEPTH)) load_pos_q <= load_pos_q + PW'(1);
						if (in_last) begin
							load_pos_q <= '0;
							state_q    <= ST_PLANE;
						end
					end
				end
				ST_PLANE: state_q <= ST_VOL;
				ST_VOL: begin
					sp_q    <= '0;
					total_q <= '0;
					state_q <= ST_CLEAR;
				end
				ST_CLEAR: begin
					if (scan_end) begin
						sp_q    <= '0;
						sx_q    <= '0;
						sy_q    <= '0;
						sz_q    <= '0;
						state_q <= ST_SCAN;
					end else begin
						sp_q <= sp_q + PW'(1);
					end
				end
				ST_SCAN: state_q <= ST_SCHK;
				ST_SCHK, ST_DEQ: begin
					if (scan_hit) begin
						head_q  <= '0;
						tail_q  <= PW'(1);
						state_q <= ST_DEQ;
					end else if (state_q == ST_DEQ && head_q != tail_q) begin
						head_q  <= head_q + PW'(1);
						state_q <= ST_DWAIT;
					end else begin
						// component closed (or scan miss): add its size if it reaches min_size, move the scan on
						if (state_q == ST_DEQ && big) begin
							total_q <= sum[vcs_pkg::TOTAL_W] ? vcs_pkg::TOTAL_SAT
							                                 : sum[vcs_pkg::TOTAL_W-1:0];
						end
						if (scan_end) begin
							state_q <= ST_DONE;
						end else begin
							sp_q    <= sp_q + PW'(1);
							state_q <= ST_SCAN;
							if ((CW'(sy_q) + CW'(1)) == c_q) begin
								sy_q <= '0;
								if ((RW'(sx_q) + RW'(1)) == r_q) begin
									sx_q <= '0;
									sz_q <= sz_q + ZW'(1);
								end else begin
									sx_q <= sx_q + XW'(1);
								end
							end else begin
								sy_q <= sy_q + YW'(1);
							end
						end
					end
				end
				ST_DWAIT: begin
					k_q     <= vcs_pkg::NB_XM;
					pend_s1 <= 1'b0;
					state_q <= ST_NBR;
				end
				ST_NBR: begin
					if (nb_hit) tail_q <= tail_q + PW'(1);
					pend_s1 <= nb_ok;
					k_q     <= k_q + 3'd1;
					if (k_q == vcs_pkg::NB_LAST) state_q <= ST_DEQ;
				end
				ST_DONE: begin
					if (res_ready) state_q <= ST_LOAD;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && in_valid && in_last) begin
			r_q <= r_cl;
			c_q <= c_cl;
			s_q <= s_cl;
		end
		if (state_q == ST_PLANE) plane_q <= PW'(r_q) * PW'(c_q);
		if (state_q == ST_VOL) vol_q <= plane_q * PW'(s_q);
		if (state_q == ST_DWAIT) begin
			{cz_q, cx_q, cy_q} <= q_rdata[QW-1:AW];
			cp_q               <= PW'(q_rdata[AW-1:0]);
		end
		if (state_q == ST_NBR) begin
			np_s1 <= nb_p;
			nx_s1 <= nb_x;
			ny_s1 <= nb_y;
			nz_s1 <= nb_z;
		end
	end

endmodule

// ===== hw/rtl/volume_component_size_sum.sv =====
// ----------------------------------------------------------------------------
// volume_component_size_sum
// sums the sizes of the 6-connected components that reach min_size in a binary volume
// ----------------------------------------------------------------------------
//  channel   dir  handshake             payload
//  s_axis    in   tvalid / tready       tdata[0] voxel, tlast last
//  m_axis    out  tvalid / tready       tdata[16:0] total
//  cfg       in   cfg_valid / cfg_ready cfg_index, cfg_data
//
//  loading takes one voxel item per cycle while tready is high; after the last item
//  the block stops taking items through setup, visited-map clearing, the scan of
//  every position and the breadth-first fill of each component, six neighbor reads
//  per voxel, all bound by the single read port of the voxel and visited rams
//  the total sits in an output register so loading of the next volume can start
//  while it waits; arst_n clears control state, ram contents are not reset
module volume_component_size_sum #(
	parameter int MAX_ROWS   = vcs_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS   = vcs_pkg::MAX_COLS_DEF,
	parameter int MAX_SLICES = vcs_pkg::MAX_SLICES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [7:0]                           s_axis_tdata,   // [0] voxel
	input  logic                                 s_axis_tlast,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [23:0]                          m_axis_tdata,   // [16:0] total
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [vcs_pkg::IDX_W-1:0]            cfg_index,
	input  logic [vcs_pkg::TOTAL_W-1:0]          cfg_data
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS * MAX_SLICES;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int YW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ZW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
	localparam int QW = ZW + XW + YW + AW;

	logic [vcs_pkg::ROWS_W-1:0]  rows_q;
	logic [vcs_pkg::COLS_W-1:0]  cols_q;
	logic [vcs_pkg::SLICE_W-1:0] slices_q;
	logic [vcs_pkg::TOTAL_W-1:0] min_q;
	logic                        out_valid_q;
	logic [vcs_pkg::TOTAL_W-1:0] out_q;

	logic                        res_valid;
	logic                        res_ready;
	logic [vcs_pkg::TOTAL_W-1:0] total;

	logic          vox_we, vox_wdata, vox_rdata;
	logic [AW-1:0] vox_waddr, vox_raddr;
	logic          vis_we, vis_wdata, vis_rdata;
	logic [AW-1:0] vis_waddr, vis_raddr;
	logic          q_we;
	logic [AW-1:0] q_waddr, q_raddr;
	logic [QW-1:0] q_wdata, q_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= vcs_pkg::ROWS_RST;
			cols_q   <= vcs_pkg::COLS_RST;
			slices_q <= vcs_pkg::SLICES_RST;
			min_q    <= vcs_pkg::MIN_RST;
		end else if (cfg_valid) begin
			unique case (vcs_pkg::reg_idx_t'(cfg_index))
				vcs_pkg::REG_ROWS:   rows_q   <= cfg_data[vcs_pkg::ROWS_W-1:0];
				vcs_pkg::REG_COLS:   cols_q   <= cfg_data[vcs_pkg::COLS_W-1:0];
				vcs_pkg::REG_SLICES: slices_q <= cfg_data[vcs_pkg::SLICE_W-1:0];
				vcs_pkg::REG_MIN:    min_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) out_q <= total;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_q};

	vcs_engine #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_COLS   (MAX_COLS),
		.MAX_SLICES (MAX_SLICES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_voxel  (s_axis_tdata[0]),
		.in_last   (s_axis_tlast),
		.rows      (rows_q),
		.cols      (cols_q),
		.slices    (slices_q),
		.min_size  (min_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.total     (total),
		.vox_we    (vox_we),
		.vox_waddr (vox_waddr),
		.vox_wdata (vox_wdata),
		.vox_raddr (vox_raddr),
		.vox_rdata (vox_rdata),
		.vis_we    (vis_we),
		.vis_waddr (vis_waddr),
		.vis_wdata (vis_wdata),
		.vis_raddr (vis_raddr),
		.vis_rdata (vis_rdata),
		.q_we      (q_we),
		.q_waddr   (q_waddr),
		.q_wdata   (q_wdata),
		.q_raddr   (q_raddr),
		.q_rdata   (q_rdata)
	);

	vcs_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_voxel_ram (
		.clk   (clk),
		.we    (vox_we),
		.waddr (vox_waddr),
		.wdata (vox_wdata),
		.raddr (vox_raddr),
		.rdata (vox_rdata)
	);

	vcs_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_visited_ram (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.raddr (vis_raddr),
		.rdata (vis_rdata)
	);

	vcs_ram #(.WIDTH(QW), .DEPTH(DEPTH)) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

endmodule

// ===== hw/rtl/vcs_checker.sv =====
// ----------------------------------------------------------------------------
// vcs_checker
// port-level checks for volume_component_size_sum
// ----------------------------------------------------------------------------
module vcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	// the block stops taking items once a volume is closed
	a_stop_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("item taken right after last");

	// a result only comes out of the processing phase
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("result appeared while loading");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[23:17] == 7'd0)
		else $error("result padding not zero");

endmodule

bind volume_component_size_sum vcs_checker u_vcs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
